/* rtl/dtrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtrm_pkg;

  localparam int KIND_W    = 2;
  localparam int ROW_IDX_W = 5;
  localparam int FLAGS_W   = 10;
  localparam int QUAL_W    = 8;
  localparam int SETTLE_W  = 3;
  localparam int COL_O_W   = 4;
  localparam int ROW_O_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARP_QUALITY    = 1'b1;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 3'd5;
  localparam logic [QUAL_W-1:0]   SHARP_RESET  = 8'd8;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_CHANGE,
    KIND_SHARPEN,
    KIND_FETCH
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WB,
    ST_PASS_WB,
    ST_PASS_END,
    ST_FULL_WB,
    ST_SCAN,
    ST_GROW,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* rtl/dtrm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dtrm_in_if;
  import dtrm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ROW_IDX_W-1:0] tile_row;
  logic [FLAGS_W-1:0]   row_flags;
  logic [QUAL_W-1:0]    pass_quality;

  modport source (output valid, kind, tile_row, row_flags, pass_quality, input ready);
  modport sink   (input valid, kind, tile_row, row_flags, pass_quality, output ready);
endinterface

`default_nettype wire

/* rtl/dtrm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dtrm_out_if;
  import dtrm_pkg::*;

  logic               valid;
  logic               ready;
  logic [COL_O_W-1:0] rect_col;
  logic [ROW_O_W-1:0] rect_row;
  logic [COL_O_W-1:0] rect_cols;
  logic [ROW_O_W-1:0] rect_rows;
  logic [QUAL_W-1:0]  rect_quality;
  logic               done_res;

  modport source (output valid, rect_col, rect_row, rect_cols, rect_rows, rect_quality,
                  done_res, input ready);
  modport sink   (input valid, rect_col, rect_row, rect_cols, rect_rows, rect_quality,
                  done_res, output ready);
endinterface

`default_nettype wire

/* rtl/dtrm_row_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtrm_row_mem #(
  parameter int DEPTH = 25,
  parameter int WIDTH = 130,
  parameter int AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output      logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // A row that was never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* rtl/dirty_tile_rectangle_merger.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dirty tile rectangle merger.
// Input channel in_i carries one command per transaction: load one row of change flags,
// start a change pass, start a sharpen pass, or fetch one rectangle. Only a fetch gives a
// transaction on out_o. Configuration writes on cfg_* are to be made only while the block
// is idle; the block itself does not enforce this. All per-tile state sits in one row
// memory (one entry per tile row, registered read). A load reads the row and writes it back.
// A pass start walks every row, one row per cycle. A full-frame fetch rewrites every row.
// Other fetches scan from the saved position and then grow the run downward, one row read
// per cycle. One command is worked on at a time;
// in_i.ready is high while the sequencer is idle.
// Results go to an output register, so the next command is taken while a rectangle waits.
// If the receiver stalls, a second fetch finishes its work and then waits for the register.
// Reset clears the valid bit of every row, so all tile state reads as zero, and sets the
// registers to a settle threshold of 5 and a sharp quality of 8.
module dirty_tile_rectangle_merger #(
  parameter int TILES_ACROSS = 10,
  parameter int TILES_DOWN   = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  dtrm_in_if.sink                               in_i,
  dtrm_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dtrm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dtrm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dtrm_pkg::*;

  localparam int TA   = TILES_ACROSS;
  localparam int TD   = TILES_DOWN;
  localparam int CW   = (TA > 1) ? $clog2(TA) : 1;
  localparam int NW   = $clog2(TA + 1);
  localparam int AW   = (TD > 1) ? $clog2(TD) : 1;
  localparam int RNW  = $clog2(TD + 1);
  localparam int CNTW = $clog2(TA * TD + 1);
  localparam int RW   = TA * (2 + SETTLE_W + QUAL_W);

  typedef struct packed {
    logic [TA-1:0]                     loaded;
    logic [TA-1:0]                     work;
    logic [TA-1:0][SETTLE_W-1:0]       settle;
    logic [TA-1:0][QUAL_W-1:0]         qual;
  } row_t;

  state_e              state_q, state_d;
  logic [SETTLE_W-1:0] thr_q;
  logic [QUAL_W-1:0]   sharp_q;
  logic [QUAL_W-1:0]   aq_q, aq_d;
  logic [QUAL_W-1:0]   pend_q, pend_d;
  logic                sharp_pass_q, sharp_pass_d;
  logic                full_q, full_d;
  logic                mapz_q, mapz_d;
  logic [CNTW-1:0]     remain_q, remain_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic [RNW-1:0]      scan_row_q, scan_row_d;
  logic [NW-1:0]       scan_col_q, scan_col_d;
  logic [RNW-1:0]      cur_row_q, cur_row_d;
  logic [NW-1:0]       cur_col_q, cur_col_d;
  logic [RNW-1:0]      top_q, top_d;
  logic [NW-1:0]       x1_q, x1_d;
  logic [NW-1:0]       len_q, len_d;
  logic [TA-1:0]       run_q, run_d;
  logic [TA-1:0]       ext_q, ext_d;
  logic [TA-1:0]       flags_q, flags_d;
  logic [COL_O_W-1:0]  res_col_q, res_col_d, res_cols_q, res_cols_d;
  logic [ROW_O_W-1:0]  res_row_q, res_row_d, res_rows_q, res_rows_d;

  logic                out_valid_q, out_valid_d;
  logic [COL_O_W-1:0]  o_col_q, o_col_d, o_cols_q, o_cols_d;
  logic [ROW_O_W-1:0]  o_row_q, o_row_d, o_rows_q, o_rows_d;
  logic [QUAL_W-1:0]   o_qual_q, o_qual_d;
  logic                o_done_q, o_done_d;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [RW-1:0]       rd_data;
  row_t                rrow, wrow, pass_row, scan_row_w, grow_row_w, full_row;
  logic [TA-1:0]       wk;
  logic [31:0]         flags_wide;
  logic [TA-1:0]       masked;
  logic                found;
  logic [CW-1:0]       x0;
  logic [NW-1:0]       x1;
  logic [TA-1:0]       run_mask, ext_mask;
  logic [NW-1:0]       pop;
  logic                last_row;
  logic                grow_match;
  logic [SETTLE_W:0]   s_inc;

  assign rrow       = row_t'(rd_data);
  assign wk         = mapz_q ? '0 : rrow.work;
  assign flags_wide = 32'(in_i.row_flags);
  assign last_row   = (cur_row_q == RNW'(TD - 1));
  assign grow_match = ((wk & ext_q) == run_q);

  // New row contents for a pass start.
  always_comb begin
    pass_row = rrow;
    s_inc    = '0;
    for (int i = 0; i < TA; i++) begin
      if (sharp_pass_q) begin
        pass_row.work[i] = (rrow.settle[i] >= thr_q) && (rrow.qual[i] > sharp_q);
      end else begin
        s_inc = {1'b0, rrow.settle[i]} + 1'b1;
        if (rrow.loaded[i]) begin
          pass_row.settle[i] = '0;
        end else if (s_inc > {1'b0, thr_q}) begin
          pass_row.settle[i] = thr_q;
        end else begin
          pass_row.settle[i] = s_inc[SETTLE_W-1:0];
        end
      end
    end
    if (!sharp_pass_q) begin
      pass_row.work = rrow.loaded;
    end
    pop = NW'($countones(pass_row.work));
  end

  // Run search in the row being scanned.
  always_comb begin
    x0 = '0;
    x1 = NW'(TA);
    for (int i = 0; i < TA; i++) begin
      masked[i] = wk[i] && (i >= int'(cur_col_q));
    end
    found = |masked;
    for (int i = TA - 1; i >= 0; i--) begin
      if (masked[i]) begin
        x0 = CW'(i);
      end
    end
    for (int i = TA - 1; i >= 0; i--) begin
      if ((i > int'(x0)) && !wk[i]) begin
        x1 = NW'(i);
      end
    end
    for (int i = 0; i < TA; i++) begin
      run_mask[i] = (i >= int'(x0)) && (i < int'(x1));
      ext_mask[i] = run_mask[i] || (i + 1 == int'(x0)) || (i == int'(x1));
    end
  end

  always_comb begin
    scan_row_w      = rrow;
    scan_row_w.work = wk & ~run_mask;
    grow_row_w      = rrow;
    grow_row_w.work = wk & ~run_q;
    full_row        = rrow;
    for (int i = 0; i < TA; i++) begin
      if (run_mask[i]) begin
        scan_row_w.qual[i] = aq_q;
      end
      if (run_q[i]) begin
        grow_row_w.qual[i] = aq_q;
      end
      full_row.qual[i] = aq_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    aq_d         = aq_q;
    pend_d       = pend_q;
    sharp_pass_d = sharp_pass_q;
    full_d       = full_q;
    mapz_d       = mapz_q;
    remain_d     = remain_q;
    count_d      = count_q;
    scan_row_d   = scan_row_q;
    scan_col_d   = scan_col_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    top_d        = top_q;
    x1_d         = x1_q;
    len_d        = len_q;
    run_d        = run_q;
    ext_d        = ext_q;
    flags_d      = flags_q;
    res_col_d    = res_col_q;
    res_row_d    = res_row_q;
    res_cols_d   = res_cols_q;
    res_rows_d   = res_rows_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    o_col_d      = o_col_q;
    o_row_d      = o_row_q;
    o_cols_d     = o_cols_q;
    o_rows_d     = o_rows_q;
    o_qual_d     = o_qual_q;
    o_done_d     = o_done_q;
    rd_en        = 1'b0;
    rd_addr      = cur_row_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = cur_row_q[AW-1:0];
    wrow         = rrow;
    in_i.ready   = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (kind_e'(in_i.kind))
            KIND_LOAD: begin
              if ({27'd0, in_i.tile_row} < 32'(TD)) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_i.tile_row);
                cur_row_d = RNW'(in_i.tile_row);
                flags_d   = flags_wide[TA-1:0];
                state_d   = ST_LOAD_WB;
              end
            end
            KIND_CHANGE, KIND_SHARPEN: begin
              sharp_pass_d = (kind_e'(in_i.kind) == KIND_SHARPEN);
              pend_d       = (kind_e'(in_i.kind) == KIND_SHARPEN) ? sharp_q : in_i.pass_quality;
              rd_en        = 1'b1;
              rd_addr      = '0;
              cur_row_d    = '0;
              count_d      = '0;
              state_d      = ST_PASS_WB;
            end
            KIND_FETCH: begin
              if (full_q) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                cur_row_d = '0;
                state_d   = ST_FULL_WB;
              end else if (scan_row_q >= RNW'(TD)) begin
                res_col_d  = '0;
                res_row_d  = '0;
                res_cols_d = '0;
                res_rows_d = '0;
                state_d    = ST_EMIT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = scan_row_q[AW-1:0];
                cur_row_d = scan_row_q;
                cur_col_d = scan_col_q;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD_WB: begin
        wr_en       = 1'b1;
        wrow        = rrow;
        wrow.loaded = flags_q;
        state_d     = ST_IDLE;
      end
      ST_PASS_WB: begin
        wr_en   = 1'b1;
        wrow    = pass_row;
        count_d = count_q + CNTW'(pop);
        if (last_row) begin
          state_d = ST_PASS_END;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_row_q + 1'b1);
          cur_row_d = cur_row_q + 1'b1;
        end
      end
      ST_PASS_END: begin
        aq_d       = pend_q;
        scan_row_d = '0;
        scan_col_d = '0;
        if ({count_q, 1'b0} > (CNTW + 1)'(TA * TD)) begin
          full_d   = 1'b1;
          mapz_d   = 1'b1;
          remain_d = '0;
        end else begin
          full_d   = 1'b0;
          mapz_d   = 1'b0;
          remain_d = count_q;
        end
        state_d = ST_IDLE;
      end
      ST_FULL_WB: begin
        wr_en = 1'b1;
        wrow  = full_row;
        if (last_row) begin
          full_d     = 1'b0;
          res_col_d  = '0;
          res_row_d  = '0;
          res_cols_d = COL_O_W'(TA);
          res_rows_d = ROW_O_W'(TD);
          state_d    = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_row_q + 1'b1);
          cur_row_d = cur_row_q + 1'b1;
        end
      end
      ST_SCAN: begin
        if (found) begin
          wr_en      = 1'b1;
          wrow       = scan_row_w;
          remain_d   = remain_q - CNTW'(x1 - NW'(x0));
          len_d      = x1 - NW'(x0);
          x1_d       = x1;
          run_d      = run_mask;
          ext_d      = ext_mask;
          top_d      = cur_row_q;
          res_col_d  = COL_O_W'(x0);
          res_row_d  = ROW_O_W'(cur_row_q);
          res_cols_d = COL_O_W'(x1 - NW'(x0));
          if (last_row) begin
            res_rows_d = ROW_O_W'(1);
            scan_row_d = cur_row_q;
            scan_col_d = x1;
            state_d    = ST_EMIT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(cur_row_q + 1'b1);
            cur_row_d = cur_row_q + 1'b1;
            state_d   = ST_GROW;
          end
        end else if (last_row) begin
          scan_row_d = RNW'(TD);
          scan_col_d = '0;
          res_col_d  = '0;
          res_row_d  = '0;
          res_cols_d = '0;
          res_rows_d = '0;
          state_d    = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_row_q + 1'b1);
          cur_row_d = cur_row_q + 1'b1;
          cur_col_d = '0;
        end
      end
      ST_GROW: begin
        if (grow_match) begin
          wr_en    = 1'b1;
          wrow     = grow_row_w;
          remain_d = remain_q - CNTW'(len_q);
          if (last_row) begin
            res_rows_d = ROW_O_W'(RNW'(TD) - top_q);
            scan_row_d = top_q;
            scan_col_d = x1_q;
            state_d    = ST_EMIT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(cur_row_q + 1'b1);
            cur_row_d = cur_row_q + 1'b1;
          end
        end else begin
          res_rows_d = ROW_O_W'(cur_row_q - top_q);
          scan_row_d = top_q;
          scan_col_d = x1_q;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The remaining-tile count is zero exactly when the work map is empty.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_col_d     = res_col_q;
          o_row_d     = res_row_q;
          o_cols_d    = res_cols_q;
          o_rows_d    = res_rows_q;
          o_qual_d    = (res_cols_q == '0) ? '0 : aq_q;
          o_done_d    = (remain_q == '0);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= SETTLE_RESET;
      sharp_q      <= SHARP_RESET;
      aq_q         <= '0;
      sharp_pass_q <= 1'b0;
      full_q       <= 1'b0;
      mapz_q       <= 1'b0;
      remain_q     <= '0;
      count_q      <= '0;
      scan_row_q   <= '0;
      scan_col_q   <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      aq_q         <= aq_d;
      sharp_pass_q <= sharp_pass_d;
      full_q       <= full_d;
      mapz_q       <= mapz_d;
      remain_q     <= remain_d;
      count_q      <= count_d;
      scan_row_q   <= scan_row_d;
      scan_col_q   <= scan_col_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SETTLE_THRESHOLD: thr_q   <= cfg_data_i[SETTLE_W-1:0];
          CFG_SHARP_QUALITY:    sharp_q <= cfg_data_i[QUAL_W-1:0];
          default:              thr_q   <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    top_q      <= top_d;
    x1_q       <= x1_d;
    len_q      <= len_d;
    run_q      <= run_d;
    ext_q      <= ext_d;
    flags_q    <= flags_d;
    res_col_q  <= res_col_d;
    res_row_q  <= res_row_d;
    res_cols_q <= res_cols_d;
    res_rows_q <= res_rows_d;
    o_col_q    <= o_col_d;
    o_row_q    <= o_row_d;
    o_cols_q   <= o_cols_d;
    o_rows_q   <= o_rows_d;
    o_qual_q   <= o_qual_d;
    o_done_q   <= o_done_d;
  end

  dtrm_row_mem #(
    .DEPTH (TD),
    .WIDTH (RW),
    .AW    (AW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (RW'(wrow)),
    .rd_data_o (rd_data)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.rect_col     = o_col_q;
  assign out_o.rect_row     = o_row_q;
  assign out_o.rect_cols    = o_cols_q;
  assign out_o.rect_rows    = o_rows_q;
  assign out_o.rect_quality = o_qual_q;
  assign out_o.done_res     = o_done_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row memory read and write hit the same row");

  a_full_map_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (remain_q == '0))
    else $error("full-frame rectangle pending with tiles left in the work map");

  a_grow_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW) |-> (cur_row_q > top_q))
    else $error("growth row is not below the rectangle top");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (!out_valid_q || out_o.ready)) |=>
    (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not return the sequencer to idle");

endmodule

`default_nettype wire
